// ===== rtl/core/gat_pkg.sv =====
// Shared types and constants for the gamepad turbo autofire block.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package gat_pkg;

	localparam int KEY_BITS  = 32;
	localparam int AXIS_BITS = 8;
	localparam int CFG_BITS  = 32;

	localparam logic [AXIS_BITS-1:0] AXIS_LOW  = 8'd64;
	localparam logic [AXIS_BITS-1:0] AXIS_HIGH = 8'd192;

	localparam logic [CFG_BITS-1:0] TURBO_MASK_RESET  = 32'd0;
	localparam logic [CFG_BITS-1:0] START_DELAY_RESET = 32'd100000;
	localparam logic [CFG_BITS-1:0] INTERVAL_RESET    = 32'd50000;

	typedef enum logic [1:0] {
		CFG_TURBO_MASK  = 2'd0,
		CFG_START_DELAY = 2'd1,
		CFG_INTERVAL    = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] start_delay;
		logic [CFG_BITS-1:0] interval;
	} turbo_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/gamepad_turbo_autofire_top.sv =====
// Top level of the gamepad turbo autofire block: stream ports, registers,
// input stage, per-key lanes and result register. Uses gat_pkg, gat_stick, gat_lane.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one controller sample per clock cycle while the result side
// is not stalled, and returns one key word for each. A sample beat lands in
// the input register, and its key word moves into the result register once
// the result side is free. The rate is set by the per-key lanes, each of which
// does its time compare and deadline add against its own deadline register
// combinationally, so a sample's autofire state is ready for the next sample.
// A stall on the result side holds the input side after one buffered beat.
// Configuration is taken on any cycle but must only be written while idle.
module gamepad_turbo_autofire_top #(
	parameter int KEY_COUNT      = 32,
	parameter int TIME_BITS      = 64,
	parameter int STICK_BIT_BASE = 24,
	parameter int HEADPHONE_BIT  = 19
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// buttons_raw[31:0], left_x[39:32], left_y[47:40], right_x[55:48],
	// right_y[63:56], now_time[127:64]
	input  wire logic [127:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// key_word[31:0]
	output logic [31:0]       m_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	localparam int KB = gat_pkg::KEY_BITS;
	localparam int AB = gat_pkg::AXIS_BITS;

	logic [KB-1:0]             turbo_mask_q;
	gat_pkg::turbo_cfg_t       turbo_cfg_q;

	logic                      valid_s1;
	logic [KB-1:0]             buttons_s1;
	logic [AB-1:0]             left_x_s1;
	logic [AB-1:0]             left_y_s1;
	logic [AB-1:0]             right_x_s1;
	logic [AB-1:0]             right_y_s1;
	logic [TIME_BITS-1:0]      now_s1;

	logic                      out_valid_q;
	logic [KB-1:0]             out_key_q;
	logic [KB-1:0]             previous_keys_q;

	logic                      out_free;
	logic                      fire;
	logic [KB-1:0]             stick_keys;
	logic [KEY_COUNT-1:0]      drop;
	logic [KB-1:0]             key_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turbo_mask_q            <= gat_pkg::TURBO_MASK_RESET;
			turbo_cfg_q.start_delay <= gat_pkg::START_DELAY_RESET;
			turbo_cfg_q.interval    <= gat_pkg::INTERVAL_RESET;
		end else if (cfg_valid) begin
			case (gat_pkg::cfg_index_t'(cfg_index))
				gat_pkg::CFG_TURBO_MASK:  turbo_mask_q            <= cfg_data;
				gat_pkg::CFG_START_DELAY: turbo_cfg_q.start_delay <= cfg_data;
				gat_pkg::CFG_INTERVAL:    turbo_cfg_q.interval    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			buttons_s1 <= s_tdata[31:0];
			left_x_s1  <= s_tdata[39:32];
			left_y_s1  <= s_tdata[47:40];
			right_x_s1 <= s_tdata[55:48];
			right_y_s1 <= s_tdata[63:56];
			now_s1     <= s_tdata[64 +: TIME_BITS];
		end
	end

	gat_stick #(
		.STICK_BIT_BASE (STICK_BIT_BASE),
		.HEADPHONE_BIT  (HEADPHONE_BIT)
	) u_stick (
		.buttons (buttons_s1),
		.left_x  (left_x_s1),
		.left_y  (left_y_s1),
		.right_x (right_x_s1),
		.right_y (right_y_s1),
		.keys    (stick_keys)
	);

	for (genvar i = 0; i < KEY_COUNT; i++) begin : g_lane
		gat_lane #(
			.TIME_BITS (TIME_BITS)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (fire),
			.mask    (turbo_mask_q[i]),
			.pressed (stick_keys[i]),
			.prev    (previous_keys_q[i]),
			.now     (now_s1),
			.cfg     (turbo_cfg_q),
			.drop    (drop[i])
		);
	end

	always_comb begin
		key_next = stick_keys;
		for (int i = 0; i < KEY_COUNT; i++) begin
			if (drop[i]) key_next[i] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q     <= 1'b0;
			previous_keys_q <= '0;
		end else begin
			if (out_free) out_valid_q <= valid_s1;
			if (fire) previous_keys_q <= key_next;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) out_key_q <= key_next;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_key_q;

	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1))
		else $error("result beat appeared without a sample in the input stage");

	a_prev_tracks_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (previous_keys_q == out_key_q))
		else $error("last key word differs from the emitted key word");

	a_no_headphone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[5'(HEADPHONE_BIT)])
		else $error("headphone bit leaked into the key word");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("input stalled while the result side could advance");

endmodule

`default_nettype wire

// ===== rtl/core/gat_stick.sv =====
// Maps the four stick axes onto direction bits and clears the headphone bit.
// Purely combinational; depends on gat_pkg for widths and axis thresholds.
`timescale 1ns / 1ps
`default_nettype none

module gat_stick #(
	parameter int STICK_BIT_BASE = 24,
	parameter int HEADPHONE_BIT  = 19
) (
	input  wire logic [gat_pkg::KEY_BITS-1:0]  buttons,
	input  wire logic [gat_pkg::AXIS_BITS-1:0] left_x,
	input  wire logic [gat_pkg::AXIS_BITS-1:0] left_y,
	input  wire logic [gat_pkg::AXIS_BITS-1:0] right_x,
	input  wire logic [gat_pkg::AXIS_BITS-1:0] right_y,
	output logic      [gat_pkg::KEY_BITS-1:0]  keys
);

	localparam logic [4:0] HP_POS   = 5'(HEADPHONE_BIT);
	localparam logic [4:0] LU_POS   = 5'(STICK_BIT_BASE + 0);
	localparam logic [4:0] LR_POS   = 5'(STICK_BIT_BASE + 1);
	localparam logic [4:0] LD_POS   = 5'(STICK_BIT_BASE + 2);
	localparam logic [4:0] LL_POS   = 5'(STICK_BIT_BASE + 3);
	localparam logic [4:0] RU_POS   = 5'(STICK_BIT_BASE + 4);
	localparam logic [4:0] RR_POS   = 5'(STICK_BIT_BASE + 5);
	localparam logic [4:0] RD_POS   = 5'(STICK_BIT_BASE + 6);
	localparam logic [4:0] RL_POS   = 5'(STICK_BIT_BASE + 7);

	always_comb begin
		keys = buttons;
		keys[HP_POS] = 1'b0;
		if (left_x < gat_pkg::AXIS_LOW)  keys[LL_POS] = 1'b1;
		if (left_x > gat_pkg::AXIS_HIGH) keys[LR_POS] = 1'b1;
		if (left_y < gat_pkg::AXIS_LOW)  keys[LU_POS] = 1'b1;
		if (left_y > gat_pkg::AXIS_HIGH) keys[LD_POS] = 1'b1;
		if (right_x < gat_pkg::AXIS_LOW)  keys[RL_POS] = 1'b1;
		if (right_x > gat_pkg::AXIS_HIGH) keys[RR_POS] = 1'b1;
		if (right_y < gat_pkg::AXIS_LOW)  keys[RU_POS] = 1'b1;
		if (right_y > gat_pkg::AXIS_HIGH) keys[RD_POS] = 1'b1;
	end

endmodule

`default_nettype wire

// ===== rtl/core/gat_lane.sv =====
// One autofire lane: the toggle deadline and phase of a single key.
// Depends on gat_pkg for the turbo timing structure.
`timescale 1ns / 1ps
`default_nettype none

module gat_lane #(
	parameter int TIME_BITS = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   mask,
	input  wire logic                   pressed,
	input  wire logic                   prev,
	input  wire logic [TIME_BITS-1:0]   now,
	input  wire gat_pkg::turbo_cfg_t    cfg,
	output logic                        drop
);

	logic [TIME_BITS-1:0] deadline_q;
	logic                 phase_q;
	logic [TIME_BITS-1:0] deadline_d;
	logic                 phase_d;
	logic                 start;
	logic                 tick;
	logic                 clear;

	always_comb begin
		start = mask && pressed && !prev && (deadline_q == '0);
		tick  = mask && pressed && !start && (now >= deadline_q);
		clear = mask && !pressed && (deadline_q != '0);
		deadline_d = deadline_q;
		phase_d    = phase_q;
		priority if (start) begin
			deadline_d = now + TIME_BITS'(cfg.start_delay);
			phase_d    = 1'b1;
		end else if (tick) begin
			deadline_d = deadline_q + TIME_BITS'(cfg.interval);
			phase_d    = !phase_q;
		end else if (clear) begin
			deadline_d = '0;
			phase_d    = 1'b0;
		end
		drop = mask && pressed && !phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadline_q <= '0;
			phase_q    <= 1'b0;
		end else if (en) begin
			deadline_q <= deadline_d;
			phase_q    <= phase_d;
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb_gamepad_turbo_autofire_top.sv =====
// Self-checking testbench for gamepad_turbo_autofire_top: stick mapping, headphone
// clearing, autofire timing and stream backpressure against an in-bench key predictor.
// Depends on gat_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps
`default_nettype none

module tb_gamepad_turbo_autofire_top;

	localparam int KEY_COUNT      = 32;
	localparam int TIME_BITS      = 64;
	localparam int STICK_BIT_BASE = 24;
	localparam int HEADPHONE_BIT  = 19;

	localparam logic [63:0] TIME_MASK = (TIME_BITS >= 64) ? {64{1'b1}} :
		((64'd1 << TIME_BITS) - 64'd1);
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 5000;
	localparam int BLOCK_ITEMS  = 104;
	localparam int SETTLE_TICKS = 8;

	typedef struct packed {
		logic [63:0] now_time;
		logic [7:0]  right_y;
		logic [7:0]  right_x;
		logic [7:0]  left_y;
		logic [7:0]  left_x;
		logic [31:0] buttons_raw;
	} gamepad_sample_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [31:0]  m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	gat_pkg::cfg_index_t cfg_index = gat_pkg::CFG_TURBO_MASK;
	logic [31:0]  cfg_data = '0;

	logic [31:0] mask_reg = gat_pkg::TURBO_MASK_RESET;
	logic [31:0] start_delay_reg = gat_pkg::START_DELAY_RESET;
	logic [31:0] interval_reg = gat_pkg::INTERVAL_RESET;
	logic [31:0] last_key_word = '0;
	logic [63:0] toggle_deadline [32];
	logic        phase_down [32];

	logic [31:0] expected_key_words [$];
	logic [31:0] oldest_key_word;
	int          error_count = 0;
	int          quiet_cycles = 0;

	int          tx_idle_pct = 27;
	int          rx_idle_pct = 60;
	logic        hold_req = 1'b0;
	logic        hold_seen = 1'b0;
	int          hold_left = 0;

	logic [31:0] held_buttons = '0;
	logic [63:0] sim_now = '0;

	gamepad_turbo_autofire_top #(
		.KEY_COUNT(KEY_COUNT),
		.TIME_BITS(TIME_BITS),
		.STICK_BIT_BASE(STICK_BIT_BASE),
		.HEADPHONE_BIT(HEADPHONE_BIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [31:0] axis_direction(input logic [7:0] axis, input int neg_pos,
		input int pos_pos);
		logic [31:0] bits;
		bits = '0;
		if (axis < gat_pkg::AXIS_LOW) begin
			bits[neg_pos % 32] = 1'b1;
		end else if (axis > gat_pkg::AXIS_HIGH) begin
			bits[pos_pos % 32] = 1'b1;
		end
		return bits;
	endfunction

	function automatic logic [31:0] predict_key_word(input gamepad_sample_t s);
		logic [31:0] keys;
		logic [63:0] now;
		keys = s.buttons_raw;
		keys[HEADPHONE_BIT % 32] = 1'b0;
		keys |= axis_direction(s.left_x, STICK_BIT_BASE + 3, STICK_BIT_BASE + 1);
		keys |= axis_direction(s.left_y, STICK_BIT_BASE + 0, STICK_BIT_BASE + 2);
		keys |= axis_direction(s.right_x, STICK_BIT_BASE + 7, STICK_BIT_BASE + 5);
		keys |= axis_direction(s.right_y, STICK_BIT_BASE + 4, STICK_BIT_BASE + 6);
		now = s.now_time & TIME_MASK;
		for (int i = 0; i < KEY_COUNT && i < 32; i++) begin
			if (!mask_reg[i])
				continue;
			if (keys[i]) begin
				if (!last_key_word[i] && toggle_deadline[i] == 64'd0) begin
					toggle_deadline[i] = (now + {32'd0, start_delay_reg}) & TIME_MASK;
					phase_down[i] = 1'b1;
				end else if (now >= toggle_deadline[i]) begin
					toggle_deadline[i] = (toggle_deadline[i] + {32'd0, interval_reg}) & TIME_MASK;
					phase_down[i] = !phase_down[i];
				end
				if (!phase_down[i])
					keys[i] = 1'b0;
			end else if (toggle_deadline[i] != 64'd0) begin
				toggle_deadline[i] = 64'd0;
				phase_down[i] = 1'b0;
			end
		end
		last_key_word = keys;
		return keys;
	endfunction

	task automatic note_error(input string what, input logic [31:0] want, input logic [31:0] got);
		error_count++;
		if (error_count <= 10)
			$display("%0t: %s: expected %h, got %h", $time, what, want, got);
	endtask

	task automatic send_sample(input logic [31:0] buttons, input logic [7:0] lx, ly, rx, ry,
		input logic [63:0] now);
		gamepad_sample_t beat;
		logic [31:0]     predicted;
		beat = '{now_time: now, right_y: ry, right_x: rx, left_y: ly, left_x: lx,
			buttons_raw: buttons};
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		s_tdata <= beat;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predicted = predict_key_word(beat);
		expected_key_words = {expected_key_words, predicted};
	endtask

	task automatic wait_for_results;
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_key_words.size() != 0);
	endtask

	task automatic write_register(input gat_pkg::cfg_index_t idx, input logic [31:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			gat_pkg::CFG_TURBO_MASK:  mask_reg = value;
			gat_pkg::CFG_START_DELAY: start_delay_reg = value;
			gat_pkg::CFG_INTERVAL:    interval_reg = value;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_axis;
		case ($urandom_range(0, 4))
			0: return 8'($urandom_range(0, 63));
			1: return 8'($urandom_range(193, 255));
			2: return 8'($urandom_range(0, 255));
			3: begin
				case ($urandom_range(0, 5))
					0: return 8'd63;
					1: return 8'd64;
					2: return 8'd192;
					3: return 8'd193;
					4: return 8'd0;
					default: return 8'd255;
				endcase
			end
			default: return 8'($urandom_range(64, 192));
		endcase
	endfunction

	function automatic logic [31:0] pick_time_setting;
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return {32{1'b1}};
			2: return $urandom;
			default: return $urandom_range(1, 8000);
		endcase
	endfunction

	function automatic logic [31:0] pick_mask;
		case ($urandom_range(0, 4))
			0: return {32{1'b1}};
			1: return 32'd0;
			2: return $urandom & $urandom;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_random_block(input int items);
		int unsigned step_max;
		wait_for_results();
		write_register(gat_pkg::CFG_TURBO_MASK, pick_mask());
		write_register(gat_pkg::CFG_START_DELAY, pick_time_setting());
		write_register(gat_pkg::CFG_INTERVAL, pick_time_setting());
		step_max = $urandom_range(1, 6000);
		repeat (items) begin
			case ($urandom_range(0, 9))
				0: held_buttons = $urandom;
				1, 2: held_buttons ^= $urandom & $urandom & $urandom;
				3: held_buttons ^= 32'd1 << $urandom_range(0, 31);
				default: ;
			endcase
			case ($urandom_range(0, 49))
				0: sim_now = {$urandom, $urandom};
				1: sim_now = {64{1'b1}} - 64'($urandom_range(0, 20000));
				2: sim_now = sim_now - 64'($urandom_range(0, 3000));
				default: sim_now = sim_now + 64'($urandom_range(0, step_max));
			endcase
			send_sample(held_buttons, pick_axis(), pick_axis(), pick_axis(), pick_axis(),
				sim_now);
		end
	endtask

	task automatic test_stick_and_headphone;
		send_sample(32'h0, 8'd128, 8'd128, 8'd128, 8'd128, 64'd0);
		send_sample({32{1'b1}}, 8'd128, 8'd128, 8'd128, 8'd128, {64{1'b1}});
		send_sample(32'h1 << HEADPHONE_BIT, 8'd128, 8'd128, 8'd128, 8'd128, 64'd1);
		send_sample(32'h0, 8'd0, 8'd0, 8'd0, 8'd0, 64'd2);
		send_sample(32'h0, 8'd255, 8'd255, 8'd255, 8'd255, 64'd3);
		send_sample(32'h0, 8'd63, 8'd63, 8'd63, 8'd63, 64'd4);
		send_sample(32'h0, 8'd64, 8'd64, 8'd64, 8'd64, 64'd5);
		send_sample(32'h0, 8'd192, 8'd192, 8'd192, 8'd192, 64'd6);
		send_sample(32'h0, 8'd193, 8'd193, 8'd193, 8'd193, 64'd7);
	endtask

	task automatic test_turbo_directed;
		wait_for_results();
		write_register(gat_pkg::CFG_TURBO_MASK, {32{1'b1}});
		write_register(gat_pkg::CFG_START_DELAY, 32'd0);
		write_register(gat_pkg::CFG_INTERVAL, 32'd0);
		repeat (3)
			send_sample(32'h0000_00ff, 8'd128, 8'd128, 8'd128, 8'd128, 64'd100);
		send_sample(32'h0, 8'd128, 8'd128, 8'd128, 8'd128, 64'd100);

		wait_for_results();
		write_register(gat_pkg::CFG_START_DELAY, {32{1'b1}});
		write_register(gat_pkg::CFG_INTERVAL, {32{1'b1}});
		send_sample(32'h0000_0f00, 8'd128, 8'd128, 8'd128, 8'd128, 64'd5);
		send_sample(32'h0000_0f00, 8'd128, 8'd128, 8'd128, 8'd128, 64'd5 + 64'hffff_fffe);
		send_sample(32'h0000_0f00, 8'd128, 8'd128, 8'd128, 8'd128, 64'd5 + 64'hffff_ffff);
		send_sample(32'h0000_0f00, 8'd128, 8'd128, 8'd128, 8'd128, 64'd5 + 64'h1_ffff_fffe);
		send_sample(32'h0, 8'd128, 8'd128, 8'd128, 8'd128, 64'd6);

		// A start deadline that wraps to zero reads as idle on the next sample.
		wait_for_results();
		write_register(gat_pkg::CFG_START_DELAY, 32'd100);
		send_sample(32'h8000_0000, 8'd128, 8'd128, 8'd128, 8'd128, 64'hffff_ffff_ffff_ff9c);
		send_sample(32'h8000_0000, 8'd128, 8'd128, 8'd128, 8'd128, 64'hffff_ffff_ffff_ffa6);
		send_sample(32'h8000_0000, 8'd128, 8'd128, 8'd128, 8'd128, 64'd0);
		send_sample(32'h0, 8'd128, 8'd128, 8'd128, 8'd128, 64'd1);
	endtask

	task automatic test_random_traffic;
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					tx_idle_pct = 27;
					rx_idle_pct <= 60;
				end
				1: begin
					tx_idle_pct = 60;
					rx_idle_pct <= 27;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct <= 0;
				end
			endcase
			repeat (5)
				run_random_block(BLOCK_ITEMS);
		end
	endtask

	task automatic test_backpressure;
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		hold_req <= ~hold_req;
		run_random_block(40);
		hold_req <= ~hold_req;
		run_random_block(40);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_seen = hold_req;
			hold_left = 0;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_key_words.size() == 0) begin
				note_error("key word with no sample pending", 'x, m_tdata);
			end else begin
				oldest_key_word = expected_key_words.pop_front();
				if (m_tdata !== oldest_key_word)
					note_error("key_word mismatch", oldest_key_word, m_tdata);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < 32; i++) begin
			toggle_deadline[i] = 64'd0;
			phase_down[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_stick_and_headphone();
		test_turbo_directed();
		test_random_traffic();
		test_backpressure();

		wait_for_results();
		repeat (SETTLE_TICKS) @(posedge clk);
		if (expected_key_words.size() != 0)
			note_error("samples left without a key word", expected_key_words[0], 'x);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
